[rtl/core/bir_pkg.sv]
// Shared constants, payload types and configuration types of the bilinear resizer.
package bir_pkg;

  localparam int SRC_MAX_W = 512;
  localparam int SRC_MAX_H = 512;

  localparam int CX_W   = $clog2(SRC_MAX_W);
  localparam int RY_W   = $clog2(SRC_MAX_H);
  localparam int SZW_W  = $clog2(SRC_MAX_W + 1);
  localparam int SZH_W  = $clog2(SRC_MAX_H + 1);
  localparam int SZ_W   = (SZW_W > SZH_W) ? SZW_W : SZH_W;
  localparam int Q_W    = SZ_W + 16;
  localparam int P_W    = 11 + Q_W;
  localparam int IX_W   = P_W - 16;
  localparam int ADDR_W = $clog2(SRC_MAX_W * SRC_MAX_H);
  localparam int CNT_W  = $clog2(Q_W + 1);

  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam logic [9:0]  SRC_W_RST = 10'd512;
  localparam logic [9:0]  SRC_H_RST = 10'd512;
  localparam logic [11:0] DST_W_RST = 12'd416;
  localparam logic [11:0] DST_H_RST = 12'd416;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [7:0]  pixel_in;
  } in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        range_error;
  } out_t;

  typedef struct packed {
    logic [SZ_W-1:0] sw;
    logic [SZ_W-1:0] sh;
    logic [11:0]     dw;
    logic [11:0]     dh;
    logic [Q_W-1:0]  hscale;
    logic [Q_W-1:0]  vscale;
    logic            ready;
  } cfg_t;

endpackage

[rtl/core/bir_div.sv]
// Restoring divider, one quotient bit per cycle, for the Q16 scale factors.
module bir_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bir_pkg::Q_W-1:0] dividend_i,
  input  logic [11:0]             divisor_i,
  output logic                    done_o,
  output logic [bir_pkg::Q_W-1:0] quot_o
);
  import bir_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [11:0]      rem_q, rem_d;
  logic [11:0]      div_q, div_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [12:0]      trial;
  logic [12:0]      diff;

  always_comb begin
    trial  = {rem_q, quot_q[Q_W-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(Q_W);
      rem_d  = '0;
      div_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d  = diff[11:0];
        quot_d = {quot_q[Q_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[11:0];
        quot_d = {quot_q[Q_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/bir_cfg.sv]
// Size registers, effective sizes and the scale factor sequencer.
module bir_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bir_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output bir_pkg::cfg_t               cfg_o
);
  import bir_pkg::*;

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_H    = 2'd1;
  localparam logic [1:0] CS_V    = 2'd2;

  logic [9:0]      src_w_q, src_h_q;
  logic [11:0]     dst_w_q, dst_h_q;
  logic [1:0]      seq_q, seq_d;
  logic            dirty_q, dirty_d;
  logic [Q_W-1:0]  hscale_q, hscale_d, vscale_q, vscale_d;
  logic            wr;
  logic [1:0]      idx;
  logic [SZ_W-1:0] sw, sh;
  logic [11:0]     dw, dh;
  logic            div_start, div_done;
  logic [Q_W-1:0]  div_dividend, div_quot;
  logic [11:0]     div_divisor;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_SRC_W: prdata = 32'(src_w_q);
      REG_SRC_H: prdata = 32'(src_h_q);
      REG_DST_W: prdata = 32'(dst_w_q);
      REG_DST_H: prdata = 32'(dst_h_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_W_RST;
      src_h_q <= SRC_H_RST;
      dst_w_q <= DST_W_RST;
      dst_h_q <= DST_H_RST;
    end else if (wr) begin
      case (idx)
        REG_SRC_W: src_w_q <= pwdata[9:0];
        REG_SRC_H: src_h_q <= pwdata[9:0];
        REG_DST_W: dst_w_q <= pwdata[11:0];
        REG_DST_H: dst_h_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, source sizes saturate at the store size
  always_comb begin
    if (src_w_q == '0) sw = SZ_W'(1);
    else if (32'(src_w_q) > SRC_MAX_W) sw = SZ_W'(SRC_MAX_W);
    else sw = SZ_W'(src_w_q);
    if (src_h_q == '0) sh = SZ_W'(1);
    else if (32'(src_h_q) > SRC_MAX_H) sh = SZ_W'(SRC_MAX_H);
    else sh = SZ_W'(src_h_q);
    dw = (dst_w_q == '0) ? 12'd1 : dst_w_q;
    dh = (dst_h_q == '0) ? 12'd1 : dst_h_q;
  end

  always_comb begin
    seq_d        = seq_q;
    hscale_d     = hscale_q;
    vscale_d     = vscale_q;
    div_start    = 1'b0;
    div_dividend = {sw - SZ_W'(1), 16'h0000};
    div_divisor  = dw - 12'd1;
    case (seq_q)
      CS_IDLE: begin
        if (dirty_q) begin
          div_start = 1'b1;
          seq_d     = CS_H;
        end
      end
      CS_H: begin
        div_dividend = {sh - SZ_W'(1), 16'h0000};
        div_divisor  = dh - 12'd1;
        if (div_done) begin
          hscale_d  = div_quot;
          div_start = 1'b1;
          seq_d     = CS_V;
        end
      end
      CS_V: begin
        if (div_done) begin
          vscale_d = div_quot;
          seq_d    = CS_IDLE;
        end
      end
      default: seq_d = CS_IDLE;
    endcase
    dirty_d = wr | (dirty_q & ~(seq_q == CS_IDLE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= CS_IDLE;
      dirty_q <= 1'b1;
    end else begin
      seq_q   <= seq_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hscale_q <= hscale_d;
    vscale_q <= vscale_d;
  end

  bir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cfg_o.sw     = sw;
  assign cfg_o.sh     = sh;
  assign cfg_o.dw     = dw;
  assign cfg_o.dh     = dh;
  assign cfg_o.hscale = hscale_q;
  assign cfg_o.vscale = vscale_q;
  assign cfg_o.ready  = (seq_q == CS_IDLE) & ~dirty_q;

endmodule

[rtl/core/bir_store.sv]
// Single-port source frame store with registered read data.
module bir_store (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       we_i,
  input  logic [bir_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                 wdata_i,
  output logic [7:0]                 rdata_o
);
  import bir_pkg::*;

  logic [7:0] mem_q [SRC_MAX_W*SRC_MAX_H];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bilinear_image_resize.sv]
// Bilinear resizer top level: item sequencer, interpolation datapath and output register.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): a write transfer stores one source
// pixel at an in-store (pos_x, pos_y) and is taken at one per cycle while idle. A compute
// transfer names a destination pixel and yields one result on the output channel
// (out_valid_o/out_ready_i, out_data_o): the Q8.8 value, or range_error with zero.
// An in-range compute occupies the sequencer after its transfer, and no new transfer is
// taken meanwhile: the x and y products from the shared scale multiplier, row
// selection, four reads of the single-port frame store, one horizontal and one
// vertical weighting step, and the load of the output register.
// An out-of-range compute goes straight to the output register.
// The output register holds a finished result while the receiver stalls; the next
// item is taken meanwhile, and a later compute waits in its last step until the
// register is free. Writes to the size registers recompute both scale factors
// with a serial divider, with in_ready_o low. At reset the size registers take
// their reset values and the same scale computation runs before the first
// transfer. Frame store contents are undefined until written.
module bilinear_image_resize (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bir_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bir_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bir_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bir_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULX = 3'd1;
  localparam logic [2:0] S_MULY = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_HOR  = 3'd5;
  localparam logic [2:0] S_VER  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  cfg_t            cfg;
  logic [2:0]      state_q, state_d;
  logic [1:0]      k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic [10:0]     px_q, px_d, py_q, py_d;
  logic [P_W-1:0]  prod_q, prod_d;
  logic [CX_W-1:0] c0_q, c0_d, c1_q, c1_d;
  logic [RY_W-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [7:0]      wx_q, wx_d, wy_q, wy_d;
  logic [7:0]      p_q [3];
  logic [7:0]      p_d [3];
  logic [15:0]     h0_q, h0_d, h1_q, h1_d, res_q, res_d;
  logic            err_q, err_d;
  out_t            out_q, out_d;

  logic              in_acc, wr_ok;
  logic [10:0]       mul_a;
  logic [Q_W-1:0]    mul_b;
  logic [IX_W-1:0]   raw, lim_c, lim_r, cl_c, cl_r;
  logic              last_col, last_row;
  logic [CX_W-1:0]   a_col;
  logic [RY_W-1:0]   a_row;
  logic              mem_en, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_rdata;
  logic [16:0]       hor0, hor1;
  logic [24:0]       ver;

  bir_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE) & cfg.ready;
  assign in_acc     = in_valid_i & in_ready_o;
  assign wr_ok      = in_acc & (in_data_i.opcode == OP_WRITE) &
                      (32'(in_data_i.pos_x) < SRC_MAX_W) & (32'(in_data_i.pos_y) < SRC_MAX_H);

  assign mul_a = (state_q == S_MULX) ? px_q : py_q;
  assign mul_b = (state_q == S_MULX) ? cfg.hscale : cfg.vscale;

  assign raw      = prod_q[P_W-1:16];
  assign lim_c    = IX_W'(cfg.sw - SZ_W'(2));
  assign lim_r    = IX_W'(cfg.sh - SZ_W'(2));
  assign cl_c     = (raw > lim_c) ? lim_c : raw;
  assign cl_r     = (raw > lim_r) ? lim_r : raw;
  assign last_col = (12'(px_q) == cfg.dw - 12'd1) | (cfg.sw == SZ_W'(1));
  assign last_row = (12'(py_q) == cfg.dh - 12'd1) | (cfg.sh == SZ_W'(1));

  assign a_col    = wr_ok ? CX_W'(in_data_i.pos_x) : (k_q[0] ? c1_q : c0_q);
  assign a_row    = wr_ok ? RY_W'(in_data_i.pos_y) : (k_q[1] ? r1_q : r0_q);
  assign mem_addr = ADDR_W'(a_row) * ADDR_W'(SRC_MAX_W) + ADDR_W'(a_col);
  assign mem_en   = wr_ok | (state_q == S_RD);
  assign mem_we   = wr_ok;

  bir_store u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_data_i.pixel_in),
    .rdata_o (mem_rdata)
  );

  assign hor0 = 17'(9'd256 - 9'(wx_q)) * 17'(p_q[0]) + 17'(wx_q) * 17'(p_q[1]);
  assign hor1 = 17'(9'd256 - 9'(wx_q)) * 17'(p_q[2]) + 17'(wx_q) * 17'(mem_rdata);
  assign ver  = 25'(9'd256 - 9'(wy_q)) * 25'(h0_q) + 25'(wy_q) * 25'(h1_q);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    px_d        = px_q;
    py_d        = py_q;
    prod_d      = prod_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    p_d         = p_q;
    h0_d        = h0_q;
    h1_d        = h1_q;
    res_d       = res_q;
    err_d       = err_q;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.opcode == OP_COMPUTE)) begin
          px_d = in_data_i.pos_x;
          py_d = in_data_i.pos_y;
          if ((12'(in_data_i.pos_x) >= cfg.dw) || (12'(in_data_i.pos_y) >= cfg.dh)) begin
            res_d   = '0;
            err_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            err_d   = 1'b0;
            state_d = S_MULX;
          end
        end
      end
      S_MULX: begin
        prod_d  = P_W'(mul_a) * P_W'(mul_b);
        state_d = S_MULY;
      end
      S_MULY: begin
        if (last_col) begin
          c0_d = CX_W'(cfg.sw - SZ_W'(1));
          c1_d = CX_W'(cfg.sw - SZ_W'(1));
          wx_d = '0;
        end else begin
          c0_d = CX_W'(cl_c);
          c1_d = CX_W'(cl_c) + CX_W'(1);
          wx_d = prod_q[15:8];
        end
        prod_d  = P_W'(mul_a) * P_W'(mul_b);
        state_d = S_ROW;
      end
      S_ROW: begin
        if (last_row) begin
          r0_d = RY_W'(cfg.sh - SZ_W'(1));
          r1_d = RY_W'(cfg.sh - SZ_W'(1));
          wy_d = '0;
        end else begin
          r0_d = RY_W'(cl_r);
          r1_d = RY_W'(cl_r) + RY_W'(1);
          wy_d = prod_q[15:8];
        end
        k_d     = '0;
        state_d = S_RD;
      end
      S_RD: begin
        case (k_q)
          2'd1:    p_d[0] = mem_rdata;
          2'd2:    p_d[1] = mem_rdata;
          2'd3:    p_d[2] = mem_rdata;
          default: ;
        endcase
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_HOR;
        end
      end
      S_HOR: begin
        h0_d    = hor0[15:0];
        h1_d    = hor1[15:0];
        state_d = S_VER;
      end
      S_VER: begin
        res_d   = ver[23:8];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.pixel_out   = res_q;
          out_d.range_error = err_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    prod_q <= prod_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    wx_q   <= wx_d;
    wy_q   <= wy_d;
    p_q    <= p_d;
    h0_q   <= h0_d;
    h1_q   <= h1_d;
    res_q  <= res_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sim/bir_checker.sv]
`timescale 1ns / 100ps
// Checker for the bilinear resizer: mirrors store and sizes, predicts and compares results.
module bir_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  bir_pkg::in_t                in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  bir_pkg::out_t               out_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [bir_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output int                          fail_count_o,
  output int                          owed_count_o,
  output int                          checked_count_o
);
  import bir_pkg::*;

  logic [7:0]  frame [SRC_MAX_W*SRC_MAX_H];
  logic [9:0]  src_w_reg;
  logic [9:0]  src_h_reg;
  logic [11:0] dst_w_reg;
  logic [11:0] dst_h_reg;
  out_t        owed_pixels [$];

  initial begin
    fail_count_o    = 0;
    owed_count_o    = 0;
    checked_count_o = 0;
  end

  function automatic int unsigned fit_size(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic int unsigned pixel_at(int unsigned col, int unsigned row);
    return 32'(frame[row * SRC_MAX_W + col]);
  endfunction

  // Q8.8 value of one source row at a destination column
  function automatic int unsigned row_q88(int unsigned col, int unsigned row,
                                          int unsigned sw, int unsigned dw);
    longint unsigned hstep;
    longint unsigned hpos;
    int unsigned     ix;
    int unsigned     wx;
    if (col == dw - 1 || sw == 1) return pixel_at(sw - 1, row) << 8;
    hstep = 64'(sw - 1);
    hstep = (hstep << 16) / 64'(dw - 1);
    hpos  = (64'(col) * hstep) >> 8;
    ix    = 32'(hpos >> 8);
    wx    = 32'(hpos & 64'd255);
    if (ix > sw - 2) ix = sw - 2;
    return (256 - wx) * pixel_at(ix, row) + wx * pixel_at(ix + 1, row);
  endfunction

  function automatic out_t predict_pixel(in_t item);
    int unsigned     sw;
    int unsigned     sh;
    int unsigned     dw;
    int unsigned     dh;
    int unsigned     x;
    int unsigned     y;
    int unsigned     iy;
    int unsigned     wy;
    int unsigned     r0;
    int unsigned     r1;
    int unsigned     value;
    longint unsigned vstep;
    longint unsigned vpos;
    out_t            res;
    sw  = fit_size(32'(src_w_reg), SRC_MAX_W);
    sh  = fit_size(32'(src_h_reg), SRC_MAX_H);
    dw  = fit_size(32'(dst_w_reg), 4095);
    dh  = fit_size(32'(dst_h_reg), 4095);
    x   = 32'(item.pos_x);
    y   = 32'(item.pos_y);
    res = '0;
    if (x >= dw || y >= dh) begin
      res.range_error = 1'b1;
    end else begin
      if (y == dh - 1 || sh == 1) begin
        value = row_q88(x, sh - 1, sw, dw);
      end else begin
        vstep = 64'(sh - 1);
        vstep = (vstep << 16) / 64'(dh - 1);
        vpos  = (64'(y) * vstep) >> 8;
        iy    = 32'(vpos >> 8);
        wy    = 32'(vpos & 64'd255);
        if (iy > sh - 2) iy = sh - 2;
        r0    = row_q88(x, iy, sw, dw);
        r1    = row_q88(x, iy + 1, sw, dw);
        value = ((256 - wy) * r0 + wy * r1) >> 8;
      end
      res.pixel_out = value[15:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      src_w_reg <= SRC_W_RST;
      src_h_reg <= SRC_H_RST;
      dst_w_reg <= DST_W_RST;
      dst_h_reg <= DST_H_RST;
      owed_pixels.delete();
      owed_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SRC_W: src_w_reg <= pwdata_i[9:0];
          REG_SRC_H: src_h_reg <= pwdata_i[9:0];
          REG_DST_W: dst_w_reg <= pwdata_i[11:0];
          REG_DST_H: dst_h_reg <= pwdata_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_pixels.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10)
            $display("unexpected result: pixel %h flag %b",
                     out_data_i.pixel_out, out_data_i.range_error);
        end else begin
          want = owed_pixels.pop_front();
          checked_count_o = checked_count_o + 1;
          if (want.pixel_out !== out_data_i.pixel_out ||
              want.range_error !== out_data_i.range_error) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("mismatch: expected pixel %h flag %b, got pixel %h flag %b",
                       want.pixel_out, want.range_error,
                       out_data_i.pixel_out, out_data_i.range_error);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_WRITE) begin
          if (in_data_i.pos_x < SRC_MAX_W && in_data_i.pos_y < SRC_MAX_H)
            frame[in_data_i.pos_y * SRC_MAX_W + in_data_i.pos_x] = in_data_i.pixel_in;
        end else begin
          owed_pixels.push_back(predict_pixel(in_data_i));
        end
      end
      owed_count_o = owed_pixels.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the bilinear resizer: clock, reset, stimulus, receiver stalls and verdict.
module tb;
  import bir_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 16;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  owed_count;
  int                  checked_count;
  int                  cycle_count;

  int unsigned cur_sw;
  int unsigned cur_sh;
  int unsigned cur_dw;
  int unsigned cur_dh;
  bit          filled [SRC_MAX_W*SRC_MAX_H];
  int          burst_left;
  int          items_sent;
  int          computes_sent;
  int          settings_used;
  bit          long_hold_armed;
  bit          long_hold_done;

  bilinear_image_resize dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bir_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count),
    .checked_count_o (checked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    cycle_count = 0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : receiver
    int run_len;
    int gap_len;
    out_ready = 1'b1;
    forever begin
      if (long_hold_armed && !long_hold_done) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      run_len = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 20);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      @(negedge clk) out_ready <= 1'b1;
      repeat (run_len - 1) @(negedge clk);
      if (gap_len > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
  end

  function automatic int unsigned in_use(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // first source index read for a destination coordinate
  function automatic int unsigned lead_tap(int unsigned pos, int unsigned src,
                                           int unsigned dst);
    longint unsigned step;
    longint unsigned at;
    int unsigned     idx;
    if (pos == dst - 1 || src == 1) return src - 1;
    step = 64'(src - 1);
    step = (step << 16) / 64'(dst - 1);
    at   = (64'(pos) * step) >> 16;
    idx  = 32'(at);
    if (idx > src - 2) idx = src - 2;
    return idx;
  endfunction

  function automatic int unsigned tap_count(int unsigned pos, int unsigned src,
                                            int unsigned dst);
    return (pos == dst - 1 || src == 1) ? 1 : 2;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
    @(negedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  task automatic put_pixel(input int unsigned x, input int unsigned y,
                           input int unsigned value);
    in_t item;
    item.opcode   = OP_WRITE;
    item.pos_x    = 11'(x);
    item.pos_y    = 11'(y);
    item.pixel_in = 8'(value);
    offer(item);
    if (x < SRC_MAX_W && y < SRC_MAX_H) filled[y * SRC_MAX_W + x] = 1'b1;
  endtask

  // stores any source pixel the request will read before sending it
  task automatic ask_pixel(input int unsigned x, input int unsigned y);
    int unsigned col0;
    int unsigned row0;
    int unsigned ncol;
    int unsigned nrow;
    int unsigned r;
    int unsigned c;
    in_t         item;
    if (x < cur_dw && y < cur_dh) begin
      col0 = lead_tap(x, cur_sw, cur_dw);
      ncol = tap_count(x, cur_sw, cur_dw);
      row0 = lead_tap(y, cur_sh, cur_dh);
      nrow = tap_count(y, cur_sh, cur_dh);
      for (r = 0; r < nrow; r++)
        for (c = 0; c < ncol; c++)
          if (!filled[(row0 + r) * SRC_MAX_W + col0 + c])
            put_pixel(col0 + c, row0 + r, $urandom_range(0, 255));
    end
    item.opcode   = OP_COMPUTE;
    item.pos_x    = 11'(x);
    item.pos_y    = 11'(y);
    item.pixel_in = 8'($urandom_range(0, 255));
    offer(item);
    computes_sent = computes_sent + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    burst_left = $urandom_range(1, 12);
  endtask

  task automatic apb_write(input logic [1:0] index, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    repeat (3) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic set_sizes(input int unsigned sw_reg, input int unsigned sh_reg,
                           input int unsigned dw_reg, input int unsigned dh_reg);
    drain();
    apb_write(REG_SRC_W, sw_reg);
    apb_write(REG_SRC_H, sh_reg);
    apb_write(REG_DST_W, dw_reg);
    apb_write(REG_DST_H, dh_reg);
    cur_sw = in_use(sw_reg, SRC_MAX_W);
    cur_sh = in_use(sh_reg, SRC_MAX_H);
    cur_dw = in_use(dw_reg, 4095);
    cur_dh = in_use(dh_reg, 4095);
    settings_used = settings_used + 1;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned xlim;
    int unsigned ylim;
    int unsigned x;
    int unsigned y;
    pick = $urandom_range(0, 99);
    xlim = (cur_dw > 2048) ? 2048 : cur_dw;
    ylim = (cur_dh > 2048) ? 2048 : cur_dh;
    if (pick < 55) begin
      x = $urandom_range(0, xlim - 1);
      y = $urandom_range(0, ylim - 1);
      if (pick < 8) x = xlim - 1;
      else if (pick < 14) y = ylim - 1;
      ask_pixel(x, y);
    end else if (pick < 67) begin
      ask_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
    end else if (pick < 90) begin
      put_pixel($urandom_range(0, cur_sw - 1), $urandom_range(0, cur_sh - 1),
                $urandom_range(0, 255));
    end else begin
      put_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 255));
    end
  endtask

  function automatic int unsigned pick_src();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 16);
  endfunction

  function automatic int unsigned pick_dst();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 48);
  endfunction

  initial begin : stimulus
    in_valid        = 1'b0;
    in_data         = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    items_sent      = 0;
    computes_sent   = 0;
    settings_used   = 1;
    long_hold_armed = 1'b0;
    long_hold_done  = 1'b0;
    burst_left      = 4;
    cur_sw          = 32'(SRC_W_RST);
    cur_sh          = 32'(SRC_H_RST);
    cur_dw          = 32'(DST_W_RST);
    cur_dh          = 32'(DST_H_RST);
    wait (rst_n);
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    // reset sizes: corners, ignored stores, out-of-range requests
    put_pixel(0, 0, 8'h00);
    put_pixel(511, 511, 8'hFF);
    put_pixel(512, 0, 8'h5A);
    put_pixel(2047, 2047, 8'hA5);
    put_pixel(3, 2047, 8'h3C);
    ask_pixel(0, 0);
    ask_pixel(415, 415);
    ask_pixel(415, 0);
    ask_pixel(0, 415);
    ask_pixel(207, 103);
    ask_pixel(416, 0);
    ask_pixel(0, 416);
    ask_pixel(2047, 2047);

    // zero sizes act as one
    set_sizes(0, 0, 0, 0);
    ask_pixel(0, 0);
    ask_pixel(1, 0);
    ask_pixel(0, 1);

    // oversized source, destination one row high
    set_sizes(1023, 700, 2048, 1);
    ask_pixel(2047, 0);
    ask_pixel(1024, 0);
    ask_pixel(1, 0);

    // source one row high, widest destination
    set_sizes(512, 1, 4095, 2048);
    ask_pixel(2047, 2047);
    ask_pixel(1365, 7);

    // source one column wide
    set_sizes(1, 9, 3, 4095);
    ask_pixel(0, 4);
    ask_pixel(2, 2047);

    set_sizes(9, 6, 23, 17);
    long_hold_armed = 1'b1;
    repeat (60) random_item();

    while (items_sent < 500) begin
      set_sizes(pick_src(), pick_src(), pick_dst(), pick_dst());
      repeat ($urandom_range(20, 50)) random_item();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d input transfers (%0d pixel requests) over %0d size settings",
             items_sent, computes_sent, settings_used);
    $display("%0d results checked, %0d failures", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
